>>> hw/rtl/hclc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hclc_pkg
// Shared types and constants of the hashed clause literal checker.
// ----------------------------------------------------------------------------
package hclc_pkg;

  // Clause shape and variable range
  localparam int LITERALS_PER_CLAUSE = 4;
  localparam int ANSWER_BITS         = 64;

  // Storage cells: one per earlier literal of a clause
  localparam int NUM_CELLS = LITERALS_PER_CLAUSE - 1;
  localparam int POS_W     = $clog2(LITERALS_PER_CLAUSE);

  // Field widths
  localparam int HASH_W = 16;
  localparam int IDX_W  = HASH_W - 1;   // hash bits that select the variable
  localparam int VAR_W  = 7;
  localparam int SEL_W  = 6;            // bit select into the answer vector

  // Reciprocal used to fold the hash index into 0..ANSWER_BITS-1
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP       = (1 << RECIP_SHIFT) / ANSWER_BITS;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int PROD_W      = IDX_W + RECIP_W;

  // Configuration port
  localparam int APB_AW = 4;
  localparam int APB_DW = 64;
  localparam logic REG_ANSWER = 1'b0;   // register index, taken from paddr[3]

  // Input request
  typedef struct packed {
    logic [HASH_W-1:0] hash_word;
    logic              new_instance;
    logic              final_clause;
  } hclc_in_t;

  // Result request
  typedef struct packed {
    logic [VAR_W-1:0] variable_number;
    logic             positive;
    logic             literal_true;
    logic             clause_end;
    logic             clause_satisfied;
    logic             verdict_valid;
    logic             all_satisfied;
  } hclc_out_t;

  // Control broadcast to every storage cell
  typedef struct packed {
    logic             shift;
    logic [VAR_W-1:0] cand;
  } hclc_cell_ctrl_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_FOLD,
    ST_PROBE
  } hclc_state_e;

endpackage

>>> hw/rtl/hashed_clause_literal_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_clause_literal_checker
// Flow: an accepted request steps through the scale, fold and probe states;
//   the probe takes one extra step per collision (at most LITERALS_PER_CLAUSE-1)
//   and commits the registered result once the output is free. The sequencer
//   works on one request at a time and takes no new one until it commits.
// Reset: verdict set, literal position and clause flag cleared, answer
//   vector zero; stored clause variables keep no reset value.
// ----------------------------------------------------------------------------
module hashed_clause_literal_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  hclc_pkg::hclc_in_t             in_req_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output hclc_pkg::hclc_out_t            out_req_o,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hclc_pkg::APB_AW-1:0]    paddr,
  input  logic [hclc_pkg::APB_DW-1:0]    pwdata,
  output logic [hclc_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);
  import hclc_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [APB_DW-1:0] answer_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[3] == REG_ANSWER);
  assign prdata = (paddr[3] == REG_ANSWER) ? answer_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      answer_q <= '0;
    end else if (cfg_wr) begin
      answer_q <= pwdata;
    end
  end

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  hclc_state_e      state_q, state_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             clause_hit_q, clause_hit_d;
  logic             inst_ok_q, inst_ok_d;
  logic             out_valid_q, out_valid_d;
  hclc_out_t        out_q, out_d;

  // Request payload and datapath registers
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             pol_q, pol_d;
  logic             final_q, final_d;
  logic [IDX_W-1:0] quot_q, quot_d;
  logic [VAR_W-1:0] cand_q, cand_d;

  logic             in_acc;
  logic             out_free;
  logic             probe_hit;
  logic             commit;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // --------------------------------------------------------------------------
  // Chain of used-variable cells
  // --------------------------------------------------------------------------
  hclc_cell_ctrl_t  cell_ctrl;
  logic [VAR_W-1:0] cell_var [NUM_CELLS];
  logic [NUM_CELLS:0] hit_chain;
  logic [NUM_CELLS-1:0] live;

  assign cell_ctrl.shift = commit;
  assign cell_ctrl.cand  = cand_q;
  assign hit_chain[0]    = 1'b0;
  assign probe_hit       = hit_chain[NUM_CELLS];

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    // cell i holds the literal i+1 places back in the clause
    assign live[i] = (pos_q > POS_W'(i));

    if (i == 0) begin : g_head
      hclc_cell u_cell (
        .clk_i  (clk_i),
        .ctrl_i (cell_ctrl),
        .live_i (live[i]),
        .var_i  (cand_q),
        .hit_i  (hit_chain[i]),
        .var_o  (cell_var[i]),
        .hit_o  (hit_chain[i+1])
      );
    end else begin : g_body
      hclc_cell u_cell (
        .clk_i  (clk_i),
        .ctrl_i (cell_ctrl),
        .live_i (live[i]),
        .var_i  (cell_var[i-1]),
        .hit_i  (hit_chain[i]),
        .var_o  (cell_var[i]),
        .hit_o  (hit_chain[i+1])
      );
    end
  end

  // --------------------------------------------------------------------------
  // Modulo datapath: quotient by reciprocal, then one correction step
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_sh;
  logic [IDX_W-1:0]  rem;
  logic [IDX_W-1:0]  rem_fix;
  logic [VAR_W-1:0]  cand_next;

  assign prod    = PROD_W'(idx_q) * PROD_W'(RECIP);
  assign prod_sh = prod >> RECIP_SHIFT;
  assign rem     = idx_q - (quot_q * IDX_W'(ANSWER_BITS));
  assign rem_fix = (rem >= IDX_W'(ANSWER_BITS)) ? (rem - IDX_W'(ANSWER_BITS)) : rem;

  // cyclic step, last variable wraps to the first
  assign cand_next = (cand_q == VAR_W'(ANSWER_BITS)) ? VAR_W'(1) : (cand_q + VAR_W'(1));

  // --------------------------------------------------------------------------
  // Literal evaluation at commit
  // --------------------------------------------------------------------------
  logic [SEL_W-1:0] sel;
  logic             lit_true;
  logic             hit_now;
  logic             clause_end;

  assign sel        = SEL_W'(cand_q - VAR_W'(1));
  assign lit_true   = (answer_q[sel] == pol_q);
  assign hit_now    = clause_hit_q | lit_true;
  assign clause_end = (pos_q == POS_W'(LITERALS_PER_CLAUSE - 1));

  // --------------------------------------------------------------------------
  // Sequencer: next state and datapath controls
  // --------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    clause_hit_d = clause_hit_q;
    inst_ok_d    = inst_ok_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_d        = out_q;
    idx_d        = idx_q;
    pol_d        = pol_q;
    final_d      = final_q;
    quot_d       = quot_q;
    cand_d       = cand_q;
    commit       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          idx_d   = in_req_i.hash_word[HASH_W-1:1];
          pol_d   = in_req_i.hash_word[0];
          final_d = in_req_i.final_clause;
          if (in_req_i.new_instance) begin
            pos_d        = '0;
            clause_hit_d = 1'b0;
            inst_ok_d    = 1'b1;
          end
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        quot_d  = prod_sh[IDX_W-1:0];
        state_d = ST_FOLD;
      end
      ST_FOLD: begin
        cand_d  = VAR_W'(rem_fix) + VAR_W'(1);
        state_d = ST_PROBE;
      end
      ST_PROBE: begin
        if (probe_hit) begin
          cand_d = cand_next;
        end else if (out_free) begin
          commit                = 1'b1;
          out_valid_d           = 1'b1;
          out_d.variable_number = cand_q;
          out_d.positive        = pol_q;
          out_d.literal_true    = lit_true;
          out_d.clause_end      = clause_end;
          out_d.clause_satisfied = clause_end & hit_now;
          out_d.verdict_valid   = clause_end & final_q;
          if (clause_end) begin
            inst_ok_d    = inst_ok_q & hit_now;
            clause_hit_d = 1'b0;
            pos_d        = '0;
          end else begin
            clause_hit_d = hit_now;
            pos_d        = pos_q + POS_W'(1);
          end
          out_d.all_satisfied = clause_end ? (inst_ok_q & hit_now) : inst_ok_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pos_q        <= '0;
      clause_hit_q <= 1'b0;
      inst_ok_q    <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      clause_hit_q <= clause_hit_d;
      inst_ok_q    <= inst_ok_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    idx_q   <= idx_d;
    pol_q   <= pol_d;
    final_q <= final_d;
    quot_q  <= quot_d;
    cand_q  <= cand_d;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_SCALE))
    else $error("accepted request did not start the sequencer");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(LITERALS_PER_CLAUSE - 1))
    else $error("literal position out of range");

  a_verdict_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((!out_req_o.verdict_valid && !out_req_o.clause_satisfied)
                     || out_req_o.clause_end))
    else $error("verdict or clause flag outside clause end");

  a_var_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (out_req_o.variable_number != '0) &&
               (out_req_o.variable_number <= VAR_W'(ANSWER_BITS)))
    else $error("variable number out of range");

endmodule

>>> hw/rtl/hclc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hclc_cell
// One storage cell of the used-variable chain: holds one variable of the
// current clause, compares it with the probe candidate and shifts it on.
// ----------------------------------------------------------------------------
module hclc_cell (
  input  logic                             clk_i,
  input  hclc_pkg::hclc_cell_ctrl_t        ctrl_i,
  input  logic                             live_i,
  input  logic [hclc_pkg::VAR_W-1:0]       var_i,
  input  logic                             hit_i,
  output logic [hclc_pkg::VAR_W-1:0]       var_o,
  output logic                             hit_o
);
  import hclc_pkg::*;

  logic [VAR_W-1:0] var_q;

  // Stored variable moves one cell down the row on each committed literal
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      var_q <= var_i;
    end
  end

  // Collision flag ripples along the row
  assign hit_o = hit_i | (live_i & (var_q == ctrl_i.cand));
  assign var_o = var_q;

endmodule
